/* rtl/core/ufkc_pkg.sv */
// ufkc_pkg: shared widths, codes, reset values and sequencer state type
// for the union-find k-clustering engine. No dependencies.
package ufkc_pkg;

    // fixed field widths of the item and result ports
    localparam int unsigned NODE_W  = 15;
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned ACT_W   = 2;

    // cluster count saturation and target register reset value
    localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;
    localparam logic [COUNT_W-1:0] TARGET_RESET = 16'd10;

    // action codes; the unused code behaves as a query
    localparam logic [ACT_W-1:0] ACT_NOTE  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_MERGE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_QUERY = 2'd2;

    // sequencer states, one-hot
    typedef enum logic [8:0] {
        S_CLEAR      = 9'b000000001,
        S_IDLE       = 9'b000000010,
        S_REDUCE     = 9'b000000100,
        S_TOUCH_A    = 9'b000001000,
        S_TOUCH_B_RD = 9'b000010000,
        S_TOUCH_B    = 9'b000100000,
        S_FIND_A     = 9'b001000000,
        S_FIND_B     = 9'b010000000,
        S_FIND_OUT   = 9'b100000000
    } t_state;

endpackage

/* rtl/core/ufkc_node_mem.sv */
// ufkc_node_mem: single-port-write, single-port-read synchronous memory
// holding one word per node. Registered read data.
// No package dependency.
module ufkc_node_mem #(
    parameter int unsigned DEPTH = 32768,
    parameter int unsigned AW    = 15,
    parameter int unsigned DW    = 17
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, data registered
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/core/ufkc_reduce.sv */
// ufkc_reduce: folds both node numbers of an item into range modulo NODES
// by reciprocal multiplication and one correcting subtract.
// Depends on ufkc_pkg.
module ufkc_reduce #(
    parameter int unsigned NODES = 32768
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  logic [ufkc_pkg::NODE_W-1:0] i_node_a,
    input  logic [ufkc_pkg::NODE_W-1:0] i_node_b,
    output logic                        o_done,
    output logic [$clog2(NODES)-1:0]    o_node_a,
    output logic [$clog2(NODES)-1:0]    o_node_b
);
    import ufkc_pkg::*;

    localparam int unsigned IW = $clog2(NODES);
    localparam int unsigned RW = NODE_W + 1;
    localparam int unsigned PW = 2 * NODE_W + 1;

    // divisor capped at the port range: above it every node is already in range
    localparam longint DIV_L = (longint'(NODES) < (longint'(1) << NODE_W)) ?
                               longint'(NODES) : (longint'(1) << NODE_W);
    localparam logic [RW-1:0] DIV   = RW'(DIV_L);
    localparam logic [RW-1:0] RECIP = RW'((longint'(1) << RW) / DIV_L);

    logic [2:0]        r_pipe;
    logic [NODE_W-1:0] r_va;
    logic [NODE_W-1:0] r_vb;
    logic [NODE_W-1:0] r_qa;
    logic [NODE_W-1:0] r_qb;
    logic [NODE_W-1:0] r_rem_a;
    logic [NODE_W-1:0] r_rem_b;
    logic [PW-1:0]     prod_a;
    logic [PW-1:0]     prod_b;
    logic [PW-1:0]     back_a;
    logic [PW-1:0]     back_b;
    logic [RW-1:0]     wide_a;
    logic [RW-1:0]     wide_b;
    logic [RW-1:0]     fix_a;
    logic [RW-1:0]     fix_b;

    // quotient estimate, low by at most one
    assign prod_a = PW'(r_va) * PW'(RECIP);
    assign prod_b = PW'(r_vb) * PW'(RECIP);

    // quotient times divisor, never above the node number
    assign back_a = PW'(r_qa) * PW'(DIV);
    assign back_b = PW'(r_qb) * PW'(DIV);

    // one correcting subtract on the partial remainder
    always_comb begin
        wide_a = {1'b0, r_rem_a};
        wide_b = {1'b0, r_rem_b};
        fix_a  = (wide_a >= DIV) ? wide_a - DIV : wide_a;
        fix_b  = (wide_b >= DIV) ? wide_b - DIV : wide_b;
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pipe <= '0;
        end else begin
            r_pipe <= {r_pipe[1:0], i_load};
        end
    end

    // node numbers, quotient estimates and partial remainders
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_va <= i_node_a;
            r_vb <= i_node_b;
        end
        r_qa    <= prod_a[PW-1:RW];
        r_qb    <= prod_b[PW-1:RW];
        r_rem_a <= r_va - back_a[NODE_W-1:0];
        r_rem_b <= r_vb - back_b[NODE_W-1:0];
    end

    assign o_done   = r_pipe[2];
    assign o_node_a = IW'(fix_a[NODE_W-1:0]);
    assign o_node_b = IW'(fix_b[NODE_W-1:0]);

endmodule

/* rtl/core/union_find_k_clustering.sv */
// union_find_k_clustering: top level, sequencer around the node memory
// (touched flag, link flag, parent per node) and the modulo reducer.
// Depends on ufkc_pkg, ufkc_node_mem, ufkc_reduce.
//
//  channel   ports                                        handshake
//  -------   -------------------------------------------  -----------------------
//  item in   i_action, i_node_a, i_node_b                 start & !busy
//  result    o_root_node, o_merged, o_clusters_left       o_done, one cycle
//  config    i_cfg_wdata (cluster_target)                 i_cfg_we
//
// After reset a clearing pass writes every node back to an untouched root,
// with busy high. An item keeps busy high through the reducer and its finds:
// a query runs one find, a note updates the touched flags of both nodes
// before it, a merge past the target check runs two. The result strobe
// follows in the next cycle with busy already low, so no new item is taken
// before the previous one is through; the receiver cannot stall.
module union_find_k_clustering #(
    parameter int unsigned NODES = 32768
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [ufkc_pkg::ACT_W-1:0]   i_action,
    input  logic [ufkc_pkg::NODE_W-1:0]  i_node_a,
    input  logic [ufkc_pkg::NODE_W-1:0]  i_node_b,
    input  logic                         i_cfg_we,
    input  logic [ufkc_pkg::COUNT_W-1:0] i_cfg_wdata,
    output logic                         o_done,
    output logic [ufkc_pkg::NODE_W-1:0]  o_root_node,
    output logic                         o_merged,
    output logic [ufkc_pkg::COUNT_W-1:0] o_clusters_left
);
    import ufkc_pkg::*;

    localparam int unsigned IW = $clog2(NODES);
    localparam int unsigned DW = IW + 2;
    localparam logic [IW-1:0] LAST_NODE = IW'(NODES - 1);

    t_state             r_state, n_state;
    logic [IW-1:0]      r_clr;
    logic [ACT_W-1:0]   r_action;
    logic [IW-1:0]      r_a, n_a;
    logic [IW-1:0]      r_b, n_b;
    logic [IW-1:0]      r_x, n_x;
    logic [IW-1:0]      r_ra, n_ra;
    logic               r_ra_touched, n_ra_touched;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [COUNT_W-1:0] r_target;
    logic               r_done, n_done;
    logic [IW-1:0]      r_root, n_root;
    logic               r_merged, n_merged;
    logic [COUNT_W-1:0] r_clusters;

    logic               accept;
    logic               red_done;
    logic [IW-1:0]      red_a, red_b;
    logic               mem_wr_en, mem_rd_en;
    logic [IW-1:0]      mem_wr_addr, mem_rd_addr;
    logic [DW-1:0]      mem_wr_data, mem_rd_data;
    logic               rd_touched, rd_linked;
    logic [IW-1:0]      rd_parent;
    logic [COUNT_W-1:0] count_inc;

    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state != S_IDLE);

    ufkc_reduce #(
        .NODES (NODES)
    ) u_reduce (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (accept),
        .i_node_a (i_node_a),
        .i_node_b (i_node_b),
        .o_done   (red_done),
        .o_node_a (red_a),
        .o_node_b (red_b)
    );

    ufkc_node_mem #(
        .DEPTH (NODES),
        .AW    (IW),
        .DW    (DW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    // node word: touched flag, link flag, parent (an unlinked node is a root)
    assign rd_touched = mem_rd_data[IW+1];
    assign rd_linked  = mem_rd_data[IW];
    assign rd_parent  = mem_rd_data[IW-1:0];
    assign count_inc  = (r_count != COUNT_MAX) ? r_count + 1'b1 : r_count;

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_a          = r_a;
        n_b          = r_b;
        n_x          = r_x;
        n_ra         = r_ra;
        n_ra_touched = r_ra_touched;
        n_count      = r_count;
        n_done       = 1'b0;
        n_root       = r_root;
        n_merged     = 1'b0;
        mem_wr_en    = 1'b0;
        mem_wr_addr  = r_clr;
        mem_wr_data  = '0;
        mem_rd_en    = 1'b0;
        mem_rd_addr  = r_x;

        unique case (r_state)
            // sweep every node back to an untouched root
            S_CLEAR: begin
                mem_wr_en = 1'b1;
                if (r_clr == LAST_NODE) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_state = S_REDUCE;
                end
            end
            // nodes in range: latch them and start reading node_a
            S_REDUCE: begin
                if (red_done) begin
                    n_a         = red_a;
                    n_b         = red_b;
                    n_x         = red_a;
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = red_a;
                    if (r_action == ACT_NOTE) begin
                        n_state = S_TOUCH_A;
                    end else if (r_action == ACT_MERGE && r_count > r_target) begin
                        n_state = S_FIND_A;
                    end else begin
                        n_state = S_FIND_OUT;
                    end
                end
            end
            // first touch of node_a counts a new cluster
            S_TOUCH_A: begin
                if (!rd_touched) begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = r_a;
                    mem_wr_data = {1'b1, rd_linked, rd_parent};
                    n_count     = count_inc;
                end
                n_state = S_TOUCH_B_RD;
            end
            // read node_b after node_a's write has landed
            S_TOUCH_B_RD: begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = r_b;
                n_state     = S_TOUCH_B;
            end
            S_TOUCH_B: begin
                if (!rd_touched) begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = r_b;
                    mem_wr_data = {1'b1, rd_linked, rd_parent};
                    n_count     = count_inc;
                end
                n_x         = r_a;
                mem_rd_en   = 1'b1;
                mem_rd_addr = r_a;
                n_state     = S_FIND_OUT;
            end
            // walk from node_a to its root, keep the root's touched flag
            S_FIND_A: begin
                if (rd_linked) begin
                    n_x         = rd_parent;
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = rd_parent;
                end else begin
                    n_ra         = r_x;
                    n_ra_touched = rd_touched;
                    n_x          = r_b;
                    mem_rd_en    = 1'b1;
                    mem_rd_addr  = r_b;
                    n_state      = S_FIND_B;
                end
            end
            // walk from node_b, then link root of a under root of b
            S_FIND_B: begin
                if (rd_linked) begin
                    n_x         = rd_parent;
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = rd_parent;
                end else begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                    if (r_ra != r_x) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = r_ra;
                        mem_wr_data = {r_ra_touched, 1'b1, r_x};
                        n_count     = r_count - 1'b1;
                        n_merged    = 1'b1;
                        n_root      = r_x;
                    end else begin
                        n_root = r_ra;
                    end
                end
            end
            // walk from node_a for the reported root
            S_FIND_OUT: begin
                if (rd_linked) begin
                    n_x         = rd_parent;
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = rd_parent;
                end else begin
                    n_root  = r_x;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_count  <= '0;
            r_target <= TARGET_RESET;
            r_done   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cfg_we) begin
                r_target <= i_cfg_wdata;
            end
        end
    end

    // item and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action <= i_action;
        end
        r_a          <= n_a;
        r_b          <= n_b;
        r_x          <= n_x;
        r_ra         <= n_ra;
        r_ra_touched <= n_ra_touched;
        if (n_done) begin
            r_root     <= n_root;
            r_merged   <= n_merged;
            r_clusters <= n_count;
        end
    end

    assign o_done          = r_done;
    assign o_root_node     = NODE_W'(r_root);
    assign o_merged        = r_merged;
    assign o_clusters_left = r_clusters;

endmodule

/* rtl/core/ufkc_checker.sv */
// ufkc_checker: port-level checks on the union-find k-clustering top level,
// bound to it below. Depends on ufkc_pkg.
module ufkc_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         o_done,
    input logic                         o_merged,
    input logic [ufkc_pkg::COUNT_W-1:0] o_clusters_left
);
    import ufkc_pkg::*;

    logic               r_have;
    logic [COUNT_W-1:0] r_last_cnt;

    // count reported by the previous result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
        end else if (o_done) begin
            r_have <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_done) begin
            r_last_cnt <= o_clusters_left;
        end
    end

    // an accepted item makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("item accepted but busy not raised");

    // a result closes the item: the block is free again
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobed while still busy");

    // a result only follows work in progress
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result without an item in progress");

    // no two results in adjacent cycles
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    // a join lowers the cluster count by exactly one
    a_merge_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_merged && r_have |-> o_clusters_left == r_last_cnt - 1'b1)
        else $error("merge did not lower the cluster count by one");

endmodule

bind union_find_k_clustering ufkc_checker u_ufkc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_done          (o_done),
    .o_merged        (o_merged),
    .o_clusters_left (o_clusters_left)
);
